### rtl/ced_pkg.sv
package ced_pkg;

    localparam int BYTE_W     = 8;
    localparam int CMD_BYTES  = 3;
    localparam int CNT_W      = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] CARET = 8'h5E;

    // One decoded group: up to three bytes, count of zero means nothing to send.
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        logic [CMD_BYTES-1:0][BYTE_W-1:0]  bytes;
    } t_cmd;

    function automatic logic f_is_hex(input logic [BYTE_W-1:0] ch);
        logic dec;
        logic alp;
        dec = (ch >= 8'h30) && (ch <= 8'h39);
        alp = (ch >= 8'h61) && (ch <= 8'h66);
        return dec || alp;
    endfunction

    function automatic logic [3:0] f_hex_val(input logic [BYTE_W-1:0] ch);
        logic [3:0] v;
        if (ch[6]) begin
            v = ch[3:0] + 4'd9;
        end else begin
            v = ch[3:0];
        end
        return v;
    endfunction

    // Add 64 below 64, subtract 64 otherwise: flip bit 6 of a 7-bit value.
    function automatic logic [BYTE_W-1:0] f_shift(input logic [6:0] ch);
        return {1'b0, ~ch[6], ch[5:0]};
    endfunction

endpackage

### rtl/ced_if.sv
interface ced_in_if import ced_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              flush;

    modport source (output valid, output in_byte, output flush, input ready);
    modport sink   (input valid, input in_byte, input flush, output ready);
endinterface

interface ced_out_if import ced_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### rtl/caret_escape_decoder_top.sv
// Double-caret escape decoder. Each input word carries one byte or a flush
// marker; two carets and two lowercase hex digits collapse into that byte, two
// carets and a 7-bit byte give that byte with bit 6 flipped, a lone caret is
// kept ahead of the byte after it, and flush sends whatever is pending and
// returns to idle. Output words carry one byte each, with last set on the final
// byte caused by an input word; a word that causes nothing gives no output. The
// front stage classifies one input word per cycle while the queue has room and
// pushes a group of one to three bytes into a QUEUE_DEPTH-entry queue; the back
// stage sends one byte per cycle through a registered output while the receiver
// is ready. Input is taken every cycle while the queue has room, so sustained
// throughput is set by the single-byte output port.
module caret_escape_decoder_top import ced_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ced_in_if.sink    i_in,
    ced_out_if.source o_out
);

    logic q_push;
    logic q_ready;
    logic q_pop;
    logic q_valid;
    t_cmd f_cmd;
    t_cmd q_cmd;

    // Front: track caret phase, build the byte group for each word.
    ced_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_cmd   (f_cmd)
    );

    // Queue: decouple the classifier from the output drain.
    ced_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: send the queued bytes one word at a time.
    ced_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

`ifndef ASSERT_OFF
    // A queued group never holds zero bytes.
    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_cmd.count != 2'd0))
        else $error("empty byte group in queue");

    // A group enters the queue only with an accepted input word.
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (i_in.valid && i_in.ready))
        else $error("queue push without accepted input");

    // The drain pops a group only when loading its last byte into the output.
    a_pop_sets_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_out.valid && o_out.last))
        else $error("group popped without last byte on output");
`endif

endmodule

### rtl/ced_front.sv
module ced_front import ced_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ced_in_if.sink i_in,
    input  logic  i_q_ready,
    output logic  o_q_push,
    output t_cmd  o_q_cmd
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_TWO,
        PH_HELD
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [6:0] r_held, n_held;
    t_cmd       cmd;
    logic       accept;
    logic       hex_pair;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign hex_pair   = f_is_hex({1'b0, r_held}) && f_is_hex(i_in.in_byte);

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        cmd     = '0;
        if (i_in.flush) begin
            case (r_phase)
                PH_ONE: begin
                    cmd.count    = 2'd1;
                    cmd.bytes[0] = CARET;
                end
                PH_TWO: begin
                    cmd.count    = 2'd2;
                    cmd.bytes[0] = CARET;
                    cmd.bytes[1] = CARET;
                end
                PH_HELD: begin
                    cmd.count    = 2'd1;
                    cmd.bytes[0] = f_shift(r_held);
                end
                default: begin
                    cmd.count = 2'd0;
                end
            endcase
            n_phase = PH_IDLE;
            n_held  = '0;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_in.in_byte == CARET) begin
                        n_phase = PH_ONE;
                    end else begin
                        cmd.count    = 2'd1;
                        cmd.bytes[0] = i_in.in_byte;
                    end
                end
                PH_ONE: begin
                    if (i_in.in_byte == CARET) begin
                        n_phase = PH_TWO;
                    end else begin
                        // lone caret: send it ahead of the byte
                        cmd.count    = 2'd2;
                        cmd.bytes[0] = CARET;
                        cmd.bytes[1] = i_in.in_byte;
                        n_phase      = PH_IDLE;
                    end
                end
                PH_TWO: begin
                    if (i_in.in_byte[7]) begin
                        cmd.count    = 2'd3;
                        cmd.bytes[0] = CARET;
                        cmd.bytes[1] = CARET;
                        cmd.bytes[2] = i_in.in_byte;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_held  = i_in.in_byte[6:0];
                        n_phase = PH_HELD;
                    end
                end
                default: begin
                    if (hex_pair) begin
                        cmd.count    = 2'd1;
                        cmd.bytes[0] = {f_hex_val({1'b0, r_held}), f_hex_val(i_in.in_byte)};
                        n_phase      = PH_IDLE;
                    end else if (i_in.in_byte == CARET) begin
                        cmd.count    = 2'd1;
                        cmd.bytes[0] = f_shift(r_held);
                        n_phase      = PH_ONE;
                    end else begin
                        cmd.count    = 2'd2;
                        cmd.bytes[0] = f_shift(r_held);
                        cmd.bytes[1] = i_in.in_byte;
                        n_phase      = PH_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_q_push = accept && (cmd.count != 2'd0);
    assign o_q_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

### rtl/ced_queue.sv
module ced_queue import ced_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_cmd              r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [FILL_W-1:0] r_fill;

    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_fill != FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_wrap(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_wrap(r_rd);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

### rtl/ced_back.sv
module ced_back import ced_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    ced_out_if.source o_out
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [CNT_W-1:0]  r_idx;
    logic              load;
    logic              fin;
    logic [BYTE_W-1:0] sel;

    assign load    = i_q_valid && (!r_valid || o_out.ready);
    assign fin     = (r_idx == i_q_cmd.count - 1'b1);
    assign o_q_pop = load && fin;

    always_comb begin
        case (r_idx)
            2'd1:    sel = i_q_cmd.bytes[1];
            2'd2:    sel = i_q_cmd.bytes[2];
            default: sel = i_q_cmd.bytes[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= fin ? '0 : r_idx + 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel;
            r_last <= fin;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

endmodule

### dv/tb.sv
// Self-checking bench for the double-caret escape decoder: every accepted input
// word runs through a predictor, and each output word is compared with the
// oldest predicted byte.
module tb;
    import ced_pkg::*;

    localparam int CLK_HALF    = 5;
    // Generous fixed limit, many times the slowest legal run.
    localparam int RUN_LIMIT   = 3_000_000;
    // Cap on the wait for outstanding words at a drain point.
    localparam int DRAIN_LIMIT = 20_000;
    // Quiet cycles after the last expected word, to cover the pipeline latency.
    localparam int TAIL_CYCLES = 10;

    // Decoder phases, tracked by the predictor.
    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_ONE_CARET,
        DEC_TWO_CARETS,
        DEC_HELD
    } t_dec_phase;

    // One predicted output word.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_word;

    logic clk;
    logic rst_n;

    ced_in_if  in_if ();
    ced_out_if out_if ();

    caret_escape_decoder_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predictor state, a copy of the decoder's phase and held byte.
    t_dec_phase  dec_phase;
    logic [6:0]  dec_held;

    // Decoded bytes still owed by the block, oldest first.
    t_out_word   owed_words[$];

    int          error_count;
    int          words_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    // Remaining cycles of a forced receiver hold-off; the receiver counts it down.
    int          hold_left;

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT;
        $display("FAIL");
        $finish;
    end

    // Lowercase hex digit value, or -1 for any other byte.
    function automatic int hex_value(input logic [BYTE_W-1:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39) begin
            return int'(ch) - 'h30;
        end
        if (ch >= 8'h61 && ch <= 8'h66) begin
            return int'(ch) - 'h61 + 10;
        end
        return -1;
    endfunction

    // Advance the predictor by one accepted word and queue the bytes it owes.
    function automatic void predict_word(input logic [BYTE_W-1:0] ch, input logic fl);
        logic [BYTE_W-1:0] outs [3];
        logic [BYTE_W-1:0] held_shifted;
        int                n;
        int                hi;
        int                lo;
        t_out_word         w;

        n = 0;
        // Held byte with 64 added below 64, subtracted otherwise.
        held_shifted = (dec_held < 7'd64) ? {1'b0, dec_held} + 8'd64
                                          : {1'b0, dec_held} - 8'd64;
        if (fl) begin
            // End of stream: release whatever is pending, then clear.
            case (dec_phase)
                DEC_ONE_CARET: begin
                    outs[0] = CARET;
                    n = 1;
                end
                DEC_TWO_CARETS: begin
                    outs[0] = CARET;
                    outs[1] = CARET;
                    n = 2;
                end
                DEC_HELD: begin
                    outs[0] = held_shifted;
                    n = 1;
                end
                default: n = 0;
            endcase
            dec_phase = DEC_IDLE;
            dec_held  = '0;
        end else begin
            case (dec_phase)
                DEC_IDLE: begin
                    if (ch == CARET) begin
                        dec_phase = DEC_ONE_CARET;
                    end else begin
                        outs[0] = ch;
                        n = 1;
                    end
                end
                DEC_ONE_CARET: begin
                    if (ch == CARET) begin
                        dec_phase = DEC_TWO_CARETS;
                    end else begin
                        // Lone caret: keep it ahead of the byte.
                        outs[0] = CARET;
                        outs[1] = ch;
                        n = 2;
                        dec_phase = DEC_IDLE;
                    end
                end
                DEC_TWO_CARETS: begin
                    if (ch[7]) begin
                        // High byte after two carets passes through as written.
                        outs[0] = CARET;
                        outs[1] = CARET;
                        outs[2] = ch;
                        n = 3;
                        dec_phase = DEC_IDLE;
                    end else begin
                        dec_held  = ch[6:0];
                        dec_phase = DEC_HELD;
                    end
                end
                default: begin
                    hi = hex_value({1'b0, dec_held});
                    lo = hex_value(ch);
                    if (hi >= 0 && lo >= 0) begin
                        outs[0] = BYTE_W'(hi * 16 + lo);
                        n = 1;
                        dec_phase = DEC_IDLE;
                    end else begin
                        outs[0] = held_shifted;
                        n = 1;
                        if (ch == CARET) begin
                            dec_phase = DEC_ONE_CARET;
                        end else begin
                            outs[1] = ch;
                            n = 2;
                            dec_phase = DEC_IDLE;
                        end
                    end
                end
            endcase
        end

        for (int i = 0; i < n; i++) begin
            w.data = outs[i];
            w.last = (i == n - 1);
            owed_words.push_back(w);
        end
    endfunction

    // Offer one word, idling first at the current sender rate. Enter and leave
    // on a falling edge; valid stays high into the next call when no gap falls.
    task automatic send_word(input logic [BYTE_W-1:0] ch, input logic fl);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.valid   = 1'b1;
        in_if.in_byte = ch;
        in_if.flush   = fl;
        // Hold the word until the block takes it.
        @(posedge clk);
        while (!in_if.ready) begin
            @(posedge clk);
        end
        predict_word(ch, fl);
        words_sent++;
        @(negedge clk);
    endtask

    // Random lowercase hex digit.
    function automatic logic [BYTE_W-1:0] rand_hex_char();
        int r;
        r = $urandom_range(15);
        return (r < 10) ? BYTE_W'('h30 + r) : BYTE_W'('h61 + r - 10);
    endfunction

    // Random bytes, escapes with random content and flushes, plus noise near the
    // hex digit boundaries and stray carets.
    task automatic send_random_words(input int count);
        int stop;
        int kind;
        int pick;
        stop = words_sent + count;
        while (words_sent < stop) begin
            kind = $urandom_range(99);
            if (kind < 28) begin
                send_word(BYTE_W'($urandom_range(255)), 1'b0);
            end else if (kind < 48) begin
                send_word(CARET, 1'b0);
                send_word(CARET, 1'b0);
                send_word(rand_hex_char(), 1'b0);
                send_word(rand_hex_char(), 1'b0);
            end else if (kind < 63) begin
                // Held byte; the word after it decides hex or shift.
                send_word(CARET, 1'b0);
                send_word(CARET, 1'b0);
                send_word(BYTE_W'($urandom_range(127)), 1'b0);
            end else if (kind < 70) begin
                send_word(CARET, 1'b0);
                send_word(CARET, 1'b0);
                send_word(BYTE_W'($urandom_range(255, 128)), 1'b0);
            end else if (kind < 78) begin
                send_word(CARET, 1'b0);
                send_word(BYTE_W'($urandom_range(255)), 1'b0);
            end else if (kind < 86) begin
                send_word(BYTE_W'($urandom_range(255)), 1'b1);
            end else begin
                pick = $urandom_range(5);
                case (pick)
                    0: send_word(8'h2F, 1'b0);
                    1: send_word(8'h3A, 1'b0);
                    2: send_word(8'h60, 1'b0);
                    3: send_word(8'h67, 1'b0);
                    default: send_word(CARET, 1'b0);
                endcase
            end
        end
    endtask

    // Drop valid and wait, bounded, until every owed word has come out.
    task automatic drain_results();
        int guard;
        in_if.valid = 1'b0;
        guard = 0;
        while (owed_words.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge clk);
            guard++;
        end
        // Words that cause nothing may still be in flight.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (owed_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, owed_words.size());
            error_count++;
            owed_words.delete();
        end
    endtask

    // Field extremes and every escape path, including each flush case.
    task automatic test_directed();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b1);          // flush while idle
        send_word(CARET, 1'b0);          // lone caret before a byte
        send_word(8'h61, 1'b0);
        send_word(CARET, 1'b0);          // hex pair
        send_word(CARET, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h31, 1'b0);
        send_word(CARET, 1'b0);          // high byte after two carets
        send_word(CARET, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(CARET, 1'b0);          // held hex digit, then a non-hex byte
        send_word(CARET, 1'b0);
        send_word(8'h66, 1'b0);
        send_word(8'h7A, 1'b0);
        send_word(CARET, 1'b0);          // held byte, then a caret
        send_word(CARET, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(CARET, 1'b0);
        send_word(8'h00, 1'b1);          // flush with one caret pending
        send_word(CARET, 1'b0);
        send_word(CARET, 1'b0);
        send_word(8'hFF, 1'b1);          // flush with two carets pending
        send_word(CARET, 1'b0);
        send_word(CARET, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h5A, 1'b1);          // flush with a held byte pending
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        send_random_words(count);
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering,
    // so the internal queue fills and input ready drops.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Drop the last offered word so the next edge cannot take it twice.
        in_if.valid   = 1'b0;
        @(posedge clk);
        hold_left = 200;
        @(negedge clk);
        send_random_words(30);
    endtask

    // Receiver: idle at the current rate unless a hold-off is running.
    initial begin
        out_if.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check every output word against the oldest owed byte.
    always @(posedge clk) begin : check_output
        t_out_word want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (owed_words.size() == 0) begin
                $display("%0t: unexpected word out_byte %h last %b",
                         $time, out_if.out_byte, out_if.last);
                error_count++;
            end else begin
                want = owed_words.pop_front();
                if (out_if.out_byte !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.data, out_if.out_byte);
                    error_count++;
                end
                if (out_if.last !== want.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, want.last, out_if.last);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset once, then the tests in turn.
    initial begin
        error_count   = 0;
        words_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        dec_phase     = DEC_IDLE;
        dec_held      = '0;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        in_if.flush   = 1'b0;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        // Pause the sender until every owed word is out.
        drain_results();
        test_random(135, 31, 80);
        drain_results();
        test_random(135, 80, 31);
        drain_results();
        test_random(135, 0, 0);
        test_backpressure();
        drain_results();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
